[rtl/core/sorted_priority_queue_core_macros.svh]
// Assertion macros for the sorted priority queue core.
// Used by the top level only; needs no other file.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SPQ_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted priority queue check failed");
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted priority queue check failed");
`else
`define SPQ_ASSERT_SAME(label, clk, rst, ante, cons)
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/core/spq_pkg.sv]
// Shared types and codes of the sorted priority queue core.
// Used by the controller, the datapath and the top level.
package spq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [31:0] weight;
    logic [7:0]  symbol;
    logic [8:0]  node_handle;
  } req_t;

  typedef struct packed {
    logic [31:0] out_weight;
    logic [7:0]  out_symbol;
    logic [8:0]  out_handle;
    logic [1:0]  status;
    logic        is_empty;
    logic        holds_one;
  } rsp_t;

  typedef struct packed {
    logic       load_item;
    logic       ins_first;
    logic       write_new_tail;
    logic       write_up;
    logic       walk_down;
    logic       write_new_after;
    logic       write_new_cur;
    logic       cnt_inc;
    logic       rd_head;
    logic       pop;
    logic       set_status;
    logic [1:0] status;
    logic       publish;
  } cmd_t;

  typedef struct packed {
    logic op_remove;
    logic empty;
    logic full;
    logic precedes;
    logic rem_one;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/spq_ctrl.sv]
// Controller state machine of the sorted priority queue core.
// Depends on spq_pkg for the command and status structs.
module spq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  spq_pkg::sts_t sts,
  output spq_pkg::cmd_t cmd
);
  import spq_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_CHK = 3'd1;
  localparam logic [2:0] S_SHIFT   = 3'd2;
  localparam logic [2:0] S_PLACE   = 3'd3;
  localparam logic [2:0] S_REM_CHK = 3'd4;
  localparam logic [2:0] S_REM_RD  = 3'd5;
  localparam logic [2:0] S_FIN     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        priority if (sts.op_remove) begin
          state_next = S_REM_CHK;
        end else if (sts.full) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_FULL;
          state_next = S_FIN;
        end else if (sts.empty) begin
          cmd.write_new_tail = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.ins_first = 1'b1;
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sts.precedes) begin
          cmd.write_up = 1'b1;
          if (sts.rem_one) begin
            state_next = S_PLACE;
          end else begin
            cmd.walk_down = 1'b1;
          end
        end else begin
          cmd.write_new_after = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next = S_FIN;
        end
      end
      S_PLACE: begin
        cmd.write_new_cur = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next = S_FIN;
      end
      S_REM_CHK: begin
        if (sts.empty) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_EMPTY;
          state_next = S_FIN;
        end else begin
          cmd.rd_head = 1'b1;
          state_next = S_REM_RD;
        end
      end
      S_REM_RD: begin
        cmd.pop = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/spq_datapath.sv]
// Datapath of the sorted priority queue core: sorted circular entry memory,
// item and result registers and the output register. Depends on spq_pkg.
module spq_datapath #(
  parameter int CAPACITY    = 256,
  parameter int WEIGHT_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  spq_pkg::req_t req,
  input  spq_pkg::cmd_t cmd,
  output spq_pkg::sts_t sts,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output spq_pkg::rsp_t rsp
);
  import spq_pkg::*;

  localparam int PW   = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int EW   = WEIGHT_BITS + 17;
  localparam logic [PW-1:0] LAST = PW'(CAPACITY - 1);

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rdata;
  logic [EW-1:0] wdata;
  logic [EW-1:0] new_entry;
  logic [PW-1:0] waddr;
  logic [PW-1:0] raddr;
  logic          wen;

  logic [PW-1:0]   head;
  logic [CNTW-1:0] count;
  logic [PW-1:0]   cur;
  logic [CNTW-1:0] rem;
  logic [CNTW:0]   tail_sum;
  logic [PW-1:0]   tail;
  logic [PW-1:0]   tail_dec;
  logic [PW-1:0]   cur_inc;
  logic [PW-1:0]   cur_dec;
  logic [PW-1:0]   head_inc;

  logic                   item_op;
  logic [WEIGHT_BITS-1:0] item_w;
  logic [7:0]             item_s;
  logic [8:0]             item_h;
  logic [WEIGHT_BITS-1:0] w_in;

  logic [WEIGHT_BITS-1:0] res_w;
  logic [7:0]             res_s;
  logic [8:0]             res_h;
  logic [1:0]             res_status;
  logic [31:0]            w_out;

  logic [WEIGHT_BITS-1:0] rd_w;
  logic [7:0]             rd_s;

  if (WEIGHT_BITS >= 32) begin : g_wide
    assign w_in  = WEIGHT_BITS'(req.weight);
    assign w_out = res_w[31:0];
  end else begin : g_narrow
    assign w_in  = req.weight[WEIGHT_BITS-1:0];
    assign w_out = 32'(res_w);
  end

  assign tail_sum = (CNTW + 1)'(head) + (CNTW + 1)'(count);
  assign tail = (tail_sum >= (CNTW + 1)'(CAPACITY)) ?
                PW'(tail_sum - (CNTW + 1)'(CAPACITY)) : PW'(tail_sum);
  assign tail_dec = (tail == '0) ? LAST : tail - 1'b1;
  assign cur_inc  = (cur == LAST) ? '0 : cur + 1'b1;
  assign cur_dec  = (cur == '0) ? LAST : cur - 1'b1;
  assign head_inc = (head == LAST) ? '0 : head + 1'b1;

  assign new_entry = {item_w, item_s, item_h};
  assign rd_w = rdata[EW-1:17];
  assign rd_s = rdata[16:9];

  always_comb begin
    wen   = 1'b1;
    waddr = cur;
    wdata = new_entry;
    priority if (cmd.write_new_tail) begin
      waddr = tail;
    end else if (cmd.write_up) begin
      waddr = cur_inc;
      wdata = rdata;
    end else if (cmd.write_new_after) begin
      waddr = cur_inc;
    end else if (cmd.write_new_cur) begin
      waddr = cur;
    end else begin
      wen = 1'b0;
    end
  end

  always_comb begin
    priority if (cmd.ins_first) begin
      raddr = tail_dec;
    end else if (cmd.walk_down) begin
      raddr = cur_dec;
    end else if (cmd.rd_head) begin
      raddr = head;
    end else begin
      raddr = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign sts.op_remove = (item_op == OP_REMOVE);
  assign sts.empty     = (count == '0);
  assign sts.full      = (count == CNTW'(CAPACITY));
  assign sts.precedes  = (item_w < rd_w) || ((item_w == rd_w) && (item_s < rd_s));
  assign sts.rem_one   = (rem == CNTW'(1));
  assign sts.out_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op <= req.operation;
      item_w  <= w_in;
      item_s  <= req.symbol;
      item_h  <= req.node_handle;
    end
    if (cmd.ins_first) begin
      cur <= tail_dec;
      rem <= count;
    end else if (cmd.walk_down) begin
      cur <= cur_dec;
      rem <= rem - 1'b1;
    end
    if (cmd.load_item) begin
      res_w      <= '0;
      res_s      <= '0;
      res_h      <= '0;
      res_status <= ST_OK;
    end else if (cmd.set_status) begin
      res_status <= cmd.status;
    end else if (cmd.pop) begin
      {res_w, res_s, res_h} <= rdata;
    end
    if (cmd.publish) begin
      rsp.out_weight <= w_out;
      rsp.out_symbol <= res_s;
      rsp.out_handle <= res_h;
      rsp.status     <= res_status;
      rsp.is_empty   <= (count == '0);
      rsp.holds_one  <= (count == CNTW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end else if (cmd.pop) begin
        count <= count - 1'b1;
        head  <= head_inc;
      end
      if (cmd.publish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/sorted_priority_queue_core.sv]
// Insert: check, backward walk moving k entries up (k at most CAPACITY - 1), then write;
// empty or full queue: check only. Remove: check, head read, pop; empty queue: check only.
// One item at a time; the backward walk reads one memory entry per cycle.
// The next item is taken the cycle after the result is loaded into the output register.
// Synchronous active-high reset empties the queue at once; no clearing pass is needed.
// Depends on spq_pkg, spq_ctrl, spq_datapath and the assertion macro header.
`include "sorted_priority_queue_core_macros.svh"

module sorted_priority_queue_core #(
  parameter int CAPACITY    = 256,
  parameter int WEIGHT_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output spq_pkg::rsp_t rsp
);
  import spq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spq_datapath #(
    .CAPACITY    (CAPACITY),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  `SPQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready)
  `SPQ_ASSERT_SAME(a_full_not_small, clk, rst, rsp_valid && (rsp.status == ST_FULL), !rsp.is_empty && !rsp.holds_one)
  `SPQ_ASSERT_SAME(a_empty_err_empty, clk, rst, rsp_valid && (rsp.status == ST_EMPTY), rsp.is_empty)
  `SPQ_ASSERT_SAME(a_flags_exclusive, clk, rst, rsp_valid, !(rsp.is_empty && rsp.holds_one))

endmodule
